/* rtl/assert_macros.svh */
// assertion macros used by civil_datetime_to_epoch.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cde_pkg.sv */
// types and tables for the civil date to epoch converter
`default_nettype none

package cde_pkg;

    localparam int unsigned YearW  = 14;
    localparam int unsigned FieldW = 7;
    localparam int unsigned EpochW = 38;

    localparam logic [YearW-1:0] YearMin = 14'd1970;
    localparam logic [YearW-1:0] YearMax = 14'd9999;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [FieldW-1:0] month;
        logic [FieldW-1:0] day;
        logic [FieldW-1:0] hour;
        logic [FieldW-1:0] minute;
        logic [FieldW-1:0] second;
    } t_dt_req;

    typedef struct packed {
        logic              valid_res;
        logic [EpochW-1:0] epoch_seconds;
    } t_dt_res;

    // days in a month of a common year, month numbered from 1
    function automatic logic [4:0] month_days(input logic [FieldW-1:0] month);
        logic [4:0] len;
        case (month)
            7'd2:                      len = 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // first day of a march-based month within the march-based year
    function automatic logic [8:0] march_doy(input logic [3:0] mp);
        logic [8:0] doy;
        case (mp)
            4'd0:    doy = 9'd0;
            4'd1:    doy = 9'd31;
            4'd2:    doy = 9'd61;
            4'd3:    doy = 9'd92;
            4'd4:    doy = 9'd122;
            4'd5:    doy = 9'd153;
            4'd6:    doy = 9'd184;
            4'd7:    doy = 9'd214;
            4'd8:    doy = 9'd245;
            4'd9:    doy = 9'd275;
            4'd10:   doy = 9'd306;
            4'd11:   doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

`default_nettype wire

/* rtl/civil_datetime_to_epoch.sv */
// Converts a UTC calendar date and time of day into Unix epoch seconds.
// One request is taken every cycle while the pipeline is not stalled, and its
// result passes six registered stages; the six stages are range check and reciprocal
// divides by 100 and 400, leap year and day check with year-of-era and time
// of day, day-of-era and era day count, day count since 1970, the scale by
// 86400, and the final add. A stalled output freezes the whole pipeline, so
// throughput is one request per cycle whenever the output is not stalled.
// Any field out of range gives valid_res low and epoch_seconds zero.
`default_nettype none
`include "assert_macros.svh"

module civil_datetime_to_epoch (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cde_pkg::t_dt_req i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output cde_pkg::t_dt_res      o_out
);

    logic en;

    // stage valid bits
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;

    // stage 1
    logic        r1_ok;
    logic [13:0] r1_year;
    logic [13:0] r1_yy;
    logic [6:0]  r1_day;
    logic [6:0]  r1_month;
    logic [3:0]  r1_mp;
    logic [6:0]  r1_hour, r1_minute, r1_second;
    logic [7:0]  r1_q100;
    logic [5:0]  r1_era;

    // stage 2
    logic        r2_ok;
    logic [8:0]  r2_yoe;
    logic [8:0]  r2_doy;
    logic [5:0]  r2_era;
    logic [16:0] r2_tod;

    // stage 3
    logic        r3_ok;
    logic [17:0] r3_doe;
    logic [23:0] r3_era_days;
    logic [16:0] r3_tod;

    // stage 4
    logic        r4_ok;
    logic [21:0] r4_days;
    logic [16:0] r4_tod;

    // stage 5
    logic        r5_ok;
    logic [37:0] r5_day_secs;
    logic [16:0] r5_tod;

    // stage 6 (output)
    cde_pkg::t_dt_res r6_res;

    // stage 1 logic
    logic        s1_ok;
    logic [13:0] s1_yy;
    logic [3:0]  s1_mp;
    logic [26:0] s1_prod_y, s1_prod_yy;

    // stage 2 logic
    logic [13:0] s2_hund;
    logic [6:0]  s2_rem100;
    logic        s2_leap;
    logic [5:0]  s2_maxd;
    logic        s2_day_ok;
    logic [13:0] s2_era400;
    logic [13:0] s2_yoe;
    logic [8:0]  s2_doy;
    logic [16:0] s2_tod;

    // stage 3 logic
    logic [1:0]  s3_c100;
    logic [17:0] s3_doe;
    logic [23:0] s3_era_days;

    // stage 4 logic
    logic [24:0] s4_days;

    // stage 5 logic
    logic [38:0] s5_prod;

    // stage 6 logic
    logic [37:0] s6_sum;

    assign en          = !r6_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r6_valid;
    assign o_out       = r6_res;

    // stage 1: range checks, march-based year, divides by 100 and 400
    always_comb begin
        s1_ok = (i_in.year >= cde_pkg::YearMin) && (i_in.year <= cde_pkg::YearMax)
             && (i_in.month >= 7'd1) && (i_in.month <= 7'd12)
             && (i_in.hour <= 7'd23) && (i_in.minute <= 7'd59) && (i_in.second <= 7'd59);
        s1_yy = (i_in.month <= 7'd2) ? i_in.year - 14'd1 : i_in.year;
        s1_mp = (i_in.month > 7'd2) ? 4'(i_in.month - 7'd3) : 4'(i_in.month + 7'd9);
        // x * 5243 >> 19 is x / 100 for every 14-bit x
        s1_prod_y  = {13'd0, i_in.year} * 27'd5243;
        s1_prod_yy = {13'd0, s1_yy} * 27'd5243;
    end

    // stage 2: leap year, day range, year of era, day of year, time of day
    always_comb begin
        s2_hund   = {6'd0, r1_q100} * 14'd100;
        s2_rem100 = 7'(r1_year - s2_hund);
        s2_leap   = ((r1_year[1:0] == 2'd0) && (s2_rem100 != 7'd0))
                 || ((s2_rem100 == 7'd0) && (r1_q100[1:0] == 2'd0));
        s2_maxd   = {1'b0, cde_pkg::month_days(r1_month)}
                  + {5'd0, (r1_month == 7'd2) && s2_leap};
        s2_day_ok = (r1_day != 7'd0) && (r1_day <= {1'b0, s2_maxd});
        s2_era400 = {8'd0, r1_era} * 14'd400;
        s2_yoe    = r1_yy - s2_era400;
        s2_doy    = cde_pkg::march_doy(r1_mp) + {2'd0, r1_day} - 9'd1;
        s2_tod    = {10'd0, r1_hour} * 17'd3600 + {10'd0, r1_minute} * 17'd60
                  + {10'd0, r1_second};
    end

    // stage 3: day of era and day count of whole eras
    always_comb begin
        s3_c100     = {1'b0, r2_yoe >= 9'd100} + {1'b0, r2_yoe >= 9'd200}
                    + {1'b0, r2_yoe >= 9'd300};
        s3_doe      = {9'd0, r2_yoe} * 18'd365 + {11'd0, r2_yoe[8:2]}
                    - {16'd0, s3_c100} + {9'd0, r2_doy};
        s3_era_days = {18'd0, r2_era} * 24'd146097;
    end

    assign s4_days = {1'b0, r3_era_days} + {7'd0, r3_doe} - 25'd719468;
    assign s5_prod = {17'd0, r4_days} * 39'd86400;
    assign s6_sum  = r5_day_secs + {21'd0, r5_tod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ok       <= s1_ok;
            r1_year     <= i_in.year;
            r1_yy       <= s1_yy;
            r1_day      <= i_in.day;
            r1_month    <= i_in.month;
            r1_mp       <= s1_mp;
            r1_hour     <= i_in.hour;
            r1_minute   <= i_in.minute;
            r1_second   <= i_in.second;
            r1_q100     <= s1_prod_y[26:19];
            r1_era      <= s1_prod_yy[26:21];

            r2_ok       <= r1_ok && s2_day_ok;
            r2_yoe      <= s2_yoe[8:0];
            r2_doy      <= s2_doy;
            r2_era      <= r1_era;
            r2_tod      <= s2_tod;

            r3_ok       <= r2_ok;
            r3_doe      <= s3_doe;
            r3_era_days <= s3_era_days;
            r3_tod      <= r2_tod;

            r4_ok       <= r3_ok;
            r4_days     <= s4_days[21:0];
            r4_tod      <= r3_tod;

            r5_ok       <= r4_ok;
            r5_day_secs <= s5_prod[37:0];
            r5_tod      <= r4_tod;

            r6_res.valid_res     <= r5_ok;
            r6_res.epoch_seconds <= r5_ok ? s6_sum : '0;
        end
    end

    `ASSERT_CLK(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_out.valid_res |-> o_out.epoch_seconds == '0, "invalid result carries a nonzero epoch")
    `ASSERT_CLK(a_epoch_bound, i_clk, i_rst_n, o_out_valid && o_out.valid_res |-> o_out.epoch_seconds <= 38'd253402300799, "epoch beyond year 9999")
    `ASSERT_CLK(a_stall_freeze, i_clk, i_rst_n, r5_valid && r6_valid && i_out_stall |=> r5_valid && r6_valid, "stage lost a request under stall")
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !r1_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire
